/* hw/rtl/lwpw_pkg.sv */
// lwpw_pkg: shared types, codes and the rgb565 to argb8888 expansion for the
// window pixel writer; no dependencies
package lwpw_pkg;

    typedef enum logic [2:0] {
        MODE_WINDOW = 3'd0,
        MODE_RGB    = 3'd1,
        MODE_INDEX  = 3'd2,
        MODE_PAL_WR = 3'd3,
        MODE_SCROLL = 3'd4,
        MODE_POLL   = 3'd5
    } mode_t;

    localparam int ADDR_W   = 17;
    localparam int ARGB_W   = 32;
    localparam int RGB_W    = 16;
    localparam int SCROLL_W = 9;
    localparam int COORD_W  = 10;
    localparam int ORIGIN_W = 9;
    localparam int INDEX_W  = 8;

    localparam logic [ARGB_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

    typedef struct packed {
        logic              bad;
        logic [ADDR_W-1:0] addr;
    } pos_t;

    function automatic logic [ARGB_W-1:0] expand565(input logic [RGB_W-1:0] p);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {p[15:11], 3'b000};
        g = {p[10:5], 2'b00};
        b = {p[4:0], 3'b000};
        return ALPHA_OPAQUE | {8'h00, r, g, b};
    endfunction

endpackage

/* hw/rtl/lcd_window_pixel_writer.sv */
// lcd_window_pixel_writer: top level of the window pixel write engine
// depends on lwpw_pkg, lwpw_cursor and lwpw_palette
//
// usage:
//   s_ channel takes one command beat per cycle; s_tuser holds the mode,
//   s_tlast marks the last pixel of a run. every beat gives exactly one
//   m_ beat: pixel writes carry the frame address and argb8888 word,
//   out-of-frame pixels carry bad_position, polls carry the dirty flag and
//   the scroll value, all other beats are all zero, tlast included.
//   m_tvalid rises in the cycle after the input handshake; throughput
//   is one beat per cycle while m_tready is high, set by the palette
//   memory's single read port, read at the input handshake and registered.
//   window, cursor and scroll state update at the handshake, so a pixel
//   may follow a set window or palette write in the very next cycle.
//   reset clears cursor, window and scroll offset and sets the dirty flag;
//   palette contents stay undefined until written, no clearing pass.
//   when m_tready is low the result register holds and s_tready drops
//   until the pending result is taken.
module lcd_window_pixel_writer #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // win_x[9:0] win_y[19:10] win_width[29:20] win_height[39:30]
    // pixel_value[55:40] palette_index[63:56] scroll_line[72:64] zero[79:73]
    input  logic [79:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_address[16:0] write_argb[48:17] scroll_value[57:49] zero[63:58]
    output logic [63:0] m_tdata,
    // write_valid[0] bad_position[1] update_needed[2]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int FRAME  = SCREEN_WIDTH * SCREEN_HEIGHT;

    lwpw_pkg::mode_t                  mode;
    logic [lwpw_pkg::COORD_W-1:0]     win_x, win_y, win_width, win_height;
    logic [lwpw_pkg::RGB_W-1:0]       pixel_value;
    logic [lwpw_pkg::INDEX_W-1:0]     palette_index;
    logic [lwpw_pkg::SCROLL_W-1:0]    scroll_line;

    logic accept;
    logic is_pixel;
    logic idx_ok;
    lwpw_pkg::pos_t pos;
    logic [lwpw_pkg::RGB_W-1:0] pal_rd_data;

    logic                           out_valid_reg, out_valid_next;
    logic                           dirty_reg, dirty_next;
    logic [lwpw_pkg::SCROLL_W-1:0]  scroll_reg, scroll_next;

    logic                           wv_next, bad_next, upd_next, use_pal_next, pal_ok_next;
    logic [lwpw_pkg::SCROLL_W-1:0]  sv_next;
    logic                           wv_reg, bad_reg, upd_reg, use_pal_reg, pal_ok_reg;
    logic                           last_reg;
    logic [lwpw_pkg::ADDR_W-1:0]    addr_reg;
    logic [lwpw_pkg::RGB_W-1:0]     rgb_reg;
    logic [lwpw_pkg::SCROLL_W-1:0]  sv_reg;
    logic [lwpw_pkg::RGB_W-1:0]     rgb_sel;
    logic [lwpw_pkg::ARGB_W-1:0]    argb;
    logic [lwpw_pkg::ADDR_W-1:0]    addr_out;

    assign mode          = lwpw_pkg::mode_t'(s_tuser);
    assign win_x         = s_tdata[9:0];
    assign win_y         = s_tdata[19:10];
    assign win_width     = s_tdata[29:20];
    assign win_height    = s_tdata[39:30];
    assign pixel_value   = s_tdata[55:40];
    assign palette_index = s_tdata[63:56];
    assign scroll_line   = s_tdata[72:64];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pixel = (mode == lwpw_pkg::MODE_RGB) || (mode == lwpw_pkg::MODE_INDEX);
    assign idx_ok   = {1'b0, palette_index} < 9'(PALETTE_DEPTH);

    lwpw_cursor #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win_en    (accept && (mode == lwpw_pkg::MODE_WINDOW)),
        .step_en   (accept && is_pixel),
        .win_x     (win_x),
        .win_y     (win_y),
        .win_width (win_width),
        .win_height(win_height),
        .pos       (pos)
    );

    lwpw_palette #(
        .DEPTH(PALETTE_DEPTH),
        .AW   (PAL_AW),
        .DW   (lwpw_pkg::RGB_W)
    ) u_palette (
        .aclk   (aclk),
        .wr_en  (accept && (mode == lwpw_pkg::MODE_PAL_WR) && idx_ok),
        .wr_addr(palette_index[PAL_AW-1:0]),
        .wr_data(pixel_value),
        .rd_en  (accept && (mode == lwpw_pkg::MODE_INDEX)),
        .rd_addr(palette_index[PAL_AW-1:0]),
        .rd_data(pal_rd_data)
    );

    // per-beat decode
    always_comb begin
        dirty_next   = dirty_reg;
        scroll_next  = scroll_reg;
        wv_next      = 1'b0;
        bad_next     = 1'b0;
        upd_next     = 1'b0;
        sv_next      = '0;
        use_pal_next = 1'b0;
        pal_ok_next  = 1'b0;
        unique case (mode) inside
            lwpw_pkg::MODE_RGB, lwpw_pkg::MODE_INDEX: begin
                bad_next     = pos.bad;
                wv_next      = !pos.bad;
                use_pal_next = (mode == lwpw_pkg::MODE_INDEX);
                pal_ok_next  = idx_ok;
                if (!pos.bad) begin
                    dirty_next = 1'b1;
                end
            end
            lwpw_pkg::MODE_SCROLL: begin
                scroll_next = scroll_line;
                dirty_next  = 1'b1;
            end
            lwpw_pkg::MODE_POLL: begin
                upd_next   = dirty_reg;
                sv_next    = dirty_reg ? scroll_reg : '0;
                dirty_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            dirty_reg     <= 1'b1;
            scroll_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                dirty_reg  <= dirty_next;
                scroll_reg <= scroll_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            wv_reg      <= wv_next;
            bad_reg     <= bad_next;
            upd_reg     <= upd_next;
            sv_reg      <= sv_next;
            use_pal_reg <= use_pal_next;
            pal_ok_reg  <= pal_ok_next;
            last_reg    <= is_pixel && s_tlast;
            addr_reg    <= pos.addr;
            rgb_reg     <= pixel_value;
        end
    end

    // palette read data is registered, so it arrives in the cycle after the read
    assign rgb_sel  = use_pal_reg ? (pal_ok_reg ? pal_rd_data : '0) : rgb_reg;
    assign argb     = wv_reg ? lwpw_pkg::expand565(rgb_sel) : '0;
    assign addr_out = wv_reg ? addr_reg : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, sv_reg, argb, addr_out};
    assign m_tuser  = {upd_reg, bad_reg, wv_reg};
    assign m_tlast  = last_reg;

    a_write_or_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flagged both written and out of frame");

    a_addr_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[16:0] < 17'(FRAME)))
        else $error("write address outside frame");

    a_poll_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (mode == lwpw_pkg::MODE_POLL)) |=> !dirty_reg)
        else $error("dirty flag still set after poll");

    a_scroll_only_on_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[57:49] != 9'd0)) |-> m_tuser[2])
        else $error("scroll value reported without update flag");

    a_pixel_sets_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_pixel && !pos.bad) |=> dirty_reg)
        else $error("good pixel write left dirty flag clear");

endmodule

/* hw/rtl/lwpw_palette.sv */
// lwpw_palette: palette memory of rgb565 words, one write and one read port,
// registered read data; no dependencies
module lwpw_palette #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/lwpw_cursor.sv */
// lwpw_cursor: window registers, write cursor and frame address generation
// depends on lwpw_pkg
module lwpw_cursor #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         win_en,
    input  logic                         step_en,
    input  logic [lwpw_pkg::COORD_W-1:0] win_x,
    input  logic [lwpw_pkg::COORD_W-1:0] win_y,
    input  logic [lwpw_pkg::COORD_W-1:0] win_width,
    input  logic [lwpw_pkg::COORD_W-1:0] win_height,
    output lwpw_pkg::pos_t               pos
);

    localparam int ROW_W = $clog2(((SCREEN_HEIGHT + 1) > 512) ? (SCREEN_HEIGHT + 1) : 512);
    localparam int EW_X  = $clog2(SCREEN_WIDTH + 1);
    localparam int EW_Y  = $clog2(SCREEN_HEIGHT + 1);
    localparam int XW    = $clog2(SCREEN_WIDTH + 1);
    localparam int SUM_W = (((ROW_W + XW) > lwpw_pkg::ADDR_W) ?
                            (ROW_W + XW) : lwpw_pkg::ADDR_W) + 1;
    localparam int FRAME = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CW    = lwpw_pkg::ADDR_W;
    localparam int OW    = lwpw_pkg::ORIGIN_W;
    localparam int ESW   = lwpw_pkg::COORD_W + 2;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [OW-1:0]    origin_col_reg, origin_col_next;
    logic [OW-1:0]    origin_row_reg, origin_row_next;
    logic [EW_X-1:0]  right_edge_reg, right_edge_next;
    logic [EW_Y-1:0]  bottom_edge_reg, bottom_edge_next;

    logic [SUM_W-1:0]      addr_sum;
    logic                  bad;
    logic [CW-1:0]         col_inc;
    logic [ROW_W-1:0]      row_inc;
    logic signed [ESW-1:0] x_end;
    logic signed [ESW-1:0] y_end;

    assign addr_sum = SUM_W'(col_reg) + SUM_W'(row_reg) * SUM_W'(SCREEN_WIDTH);
    assign bad      = addr_sum >= SUM_W'(FRAME);
    assign pos.bad  = bad;
    assign pos.addr = addr_sum[CW-1:0];

    assign col_inc = col_reg + CW'(1);
    assign row_inc = row_reg + ROW_W'(1);

    assign x_end = $signed({{2{win_x[lwpw_pkg::COORD_W-1]}}, win_x})
                 + $signed({2'b00, win_width});
    assign y_end = $signed({{2{win_y[lwpw_pkg::COORD_W-1]}}, win_y})
                 + $signed({2'b00, win_height});

    always_comb begin
        col_next         = col_reg;
        row_next         = row_reg;
        origin_col_next  = origin_col_reg;
        origin_row_next  = origin_row_reg;
        right_edge_next  = right_edge_reg;
        bottom_edge_next = bottom_edge_reg;
        if (win_en) begin
            origin_col_next = win_x[lwpw_pkg::COORD_W-1] ? '0 : win_x[OW-1:0];
            origin_row_next = win_y[lwpw_pkg::COORD_W-1] ? '0 : win_y[OW-1:0];
            col_next        = CW'(origin_col_next);
            row_next        = ROW_W'(origin_row_next);
            if (x_end <= $signed(ESW'(0))) begin
                right_edge_next = '0;
            end else if (x_end > $signed(ESW'(SCREEN_WIDTH))) begin
                right_edge_next = EW_X'(SCREEN_WIDTH);
            end else begin
                right_edge_next = x_end[EW_X-1:0];
            end
            if (y_end <= $signed(ESW'(0))) begin
                bottom_edge_next = '0;
            end else if (y_end > $signed(ESW'(SCREEN_HEIGHT))) begin
                bottom_edge_next = EW_Y'(SCREEN_HEIGHT);
            end else begin
                bottom_edge_next = y_end[EW_Y-1:0];
            end
        end else if (step_en && !bad) begin
            col_next = col_inc;
            if (col_inc == CW'(right_edge_reg)) begin
                col_next = CW'(origin_col_reg);
                row_next = row_inc;
                if (row_inc == ROW_W'(bottom_edge_reg)) begin
                    row_next = ROW_W'(origin_row_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            origin_col_reg  <= '0;
            origin_row_reg  <= '0;
            right_edge_reg  <= '0;
            bottom_edge_reg <= '0;
        end else begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            origin_col_reg  <= origin_col_next;
            origin_row_reg  <= origin_row_next;
            right_edge_reg  <= right_edge_next;
            bottom_edge_reg <= bottom_edge_next;
        end
    end

    a_win_sets_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        win_en |=> (col_reg == CW'(origin_col_reg)) && (row_reg == ROW_W'(origin_row_reg)))
        else $error("cursor not at window origin after set window");

    a_bad_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !win_en && bad) |=> $stable(col_reg) && $stable(row_reg))
        else $error("cursor moved on an out-of-frame pixel");

    a_edges_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (right_edge_reg <= EW_X'(SCREEN_WIDTH)) && (bottom_edge_reg <= EW_Y'(SCREEN_HEIGHT)))
        else $error("window edge beyond screen");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for lcd_window_pixel_writer, with a queue-fed stream
// driver, a random-stall result monitor and an in-bench cursor and palette predictor
// depends on lwpw_pkg and the lcd_window_pixel_writer rtl
module tb;

    localparam int SCREEN_W       = 240;
    localparam int SCREEN_H       = 320;
    localparam int PAL_DEPTH      = 256;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 100;
    localparam int PHASE_ITEMS    = 195;
    localparam int MAX_REPORTS    = 10;

    // spare mode codes, ignored by the block
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]                          mode;
        logic signed [lwpw_pkg::COORD_W-1:0] win_x;
        logic signed [lwpw_pkg::COORD_W-1:0] win_y;
        logic [lwpw_pkg::COORD_W-1:0]        win_width;
        logic [lwpw_pkg::COORD_W-1:0]        win_height;
        logic [lwpw_pkg::RGB_W-1:0]          pixel_value;
        logic [lwpw_pkg::INDEX_W-1:0]        palette_index;
        logic [lwpw_pkg::SCROLL_W-1:0]       scroll_line;
        logic                                run_end;
    } cmd_t;

    typedef struct packed {
        logic                          write_valid;
        logic [lwpw_pkg::ADDR_W-1:0]   write_address;
        logic [lwpw_pkg::ARGB_W-1:0]   write_argb;
        logic                          bad_position;
        logic                          update_needed;
        logic [lwpw_pkg::SCROLL_W-1:0] scroll_value;
        logic                          run_done;
    } response_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    lcd_window_pixel_writer #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H),
        .PALETTE_DEPTH(PAL_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    cmd_t      pending_cmds[$];
    response_t pending_responses[$];
    cmd_t      offered_cmd;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int in_beats = 0;
    int queued_items = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;

    logic [lwpw_pkg::INDEX_W-1:0] loaded_idx[$];
    bit                           idx_loaded[PAL_DEPTH];

    // predictor state
    int unsigned                   cur_col = 0;
    int unsigned                   cur_row = 0;
    int unsigned                   org_col = 0;
    int unsigned                   org_row = 0;
    int unsigned                   edge_col = 0;
    int unsigned                   edge_row = 0;
    logic [lwpw_pkg::SCROLL_W-1:0] scroll_reg = '0;
    bit                            dirty_reg = 1'b1;
    logic [lwpw_pkg::RGB_W-1:0]    palette_model[PAL_DEPTH];

    function automatic logic [lwpw_pkg::ARGB_W-1:0] rgb565_to_argb(
        input logic [lwpw_pkg::RGB_W-1:0] p);
        return {8'hFF, p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
    endfunction

    function automatic int unsigned clamp_window_edge(input int start, input int len,
                                                      input int limit);
        int span;
        span = start + len;
        if (span <= 0)
            return 0;
        if (span > limit)
            return limit;
        return span;
    endfunction

    function automatic response_t writer_response(input cmd_t c);
        response_t                  r;
        int                         x;
        int                         y;
        int unsigned                addr;
        logic [lwpw_pkg::RGB_W-1:0] rgb;
        r = '0;
        case (c.mode)
            lwpw_pkg::MODE_WINDOW: begin
                x = $signed(c.win_x);
                y = $signed(c.win_y);
                org_col = (x > 0) ? x : 0;
                org_row = (y > 0) ? y : 0;
                cur_col = org_col;
                cur_row = org_row;
                edge_col = clamp_window_edge(x, int'({1'b0, c.win_width}), SCREEN_W);
                edge_row = clamp_window_edge(y, int'({1'b0, c.win_height}), SCREEN_H);
            end
            lwpw_pkg::MODE_RGB, lwpw_pkg::MODE_INDEX: begin
                rgb = (c.mode == lwpw_pkg::MODE_RGB) ? c.pixel_value
                                                     : palette_model[c.palette_index];
                r.run_done = c.run_end;
                addr = cur_col + cur_row * SCREEN_W;
                if (addr >= SCREEN_W * SCREEN_H) begin
                    r.bad_position = 1'b1;
                end else begin
                    dirty_reg = 1'b1;
                    r.write_valid = 1'b1;
                    r.write_address = addr[lwpw_pkg::ADDR_W-1:0];
                    r.write_argb = rgb565_to_argb(rgb);
                    cur_col = (cur_col + 1) & 32'h1FFFF;
                    if (cur_col == edge_col) begin
                        cur_col = org_col;
                        cur_row = cur_row + 1;
                        if (cur_row == edge_row)
                            cur_row = org_row;
                    end
                end
            end
            lwpw_pkg::MODE_PAL_WR: palette_model[c.palette_index] = c.pixel_value;
            lwpw_pkg::MODE_SCROLL: begin
                scroll_reg = c.scroll_line;
                dirty_reg = 1'b1;
            end
            lwpw_pkg::MODE_POLL: begin
                r.update_needed = dirty_reg;
                r.scroll_value = dirty_reg ? scroll_reg : '0;
                dirty_reg = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // stimulus helpers
    function automatic cmd_t random_cmd();
        cmd_t c;
        c.mode = lwpw_pkg::MODE_POLL;
        c.win_x = lwpw_pkg::COORD_W'($urandom);
        c.win_y = lwpw_pkg::COORD_W'($urandom);
        c.win_width = lwpw_pkg::COORD_W'($urandom);
        c.win_height = lwpw_pkg::COORD_W'($urandom);
        c.pixel_value = lwpw_pkg::RGB_W'($urandom);
        c.palette_index = lwpw_pkg::INDEX_W'($urandom);
        c.scroll_line = lwpw_pkg::SCROLL_W'($urandom_range(0, SCREEN_H));
        c.run_end = 1'($urandom);
        return c;
    endfunction

    function automatic logic [lwpw_pkg::INDEX_W-1:0] pick_loaded_index();
        return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
    endfunction

    task automatic queue_cmd(input cmd_t c);
        if (c.mode == lwpw_pkg::MODE_PAL_WR && !idx_loaded[c.palette_index]) begin
            idx_loaded[c.palette_index] = 1'b1;
            loaded_idx.push_back(c.palette_index);
        end
        pending_cmds.push_back(c);
        queued_items++;
    endtask

    task automatic queue_window(input int x, input int y, input int w, input int h);
        cmd_t c;
        c = random_cmd();
        c.mode = lwpw_pkg::MODE_WINDOW;
        c.win_x = lwpw_pkg::COORD_W'(x);
        c.win_y = lwpw_pkg::COORD_W'(y);
        c.win_width = lwpw_pkg::COORD_W'(w);
        c.win_height = lwpw_pkg::COORD_W'(h);
        queue_cmd(c);
    endtask

    task automatic queue_pixel(input bit indexed, input logic [lwpw_pkg::RGB_W-1:0] value,
                               input logic [lwpw_pkg::INDEX_W-1:0] idx, input bit last);
        cmd_t c;
        c = random_cmd();
        c.mode = indexed ? lwpw_pkg::MODE_INDEX : lwpw_pkg::MODE_RGB;
        c.pixel_value = value;
        c.palette_index = idx;
        c.run_end = last;
        queue_cmd(c);
    endtask

    task automatic queue_simple(input logic [2:0] mode,
                                input logic [lwpw_pkg::INDEX_W-1:0] idx,
                                input logic [lwpw_pkg::RGB_W-1:0] value,
                                input logic [lwpw_pkg::SCROLL_W-1:0] line);
        cmd_t c;
        c = random_cmd();
        c.mode = mode;
        c.palette_index = idx;
        c.pixel_value = value;
        c.scroll_line = line;
        queue_cmd(c);
    endtask

    task automatic queue_side_item();
        case ($urandom_range(0, 2))
            0: queue_simple(lwpw_pkg::MODE_PAL_WR, lwpw_pkg::INDEX_W'($urandom),
                            lwpw_pkg::RGB_W'($urandom), '0);
            1: queue_simple(lwpw_pkg::MODE_SCROLL, '0, '0,
                            lwpw_pkg::SCROLL_W'($urandom_range(0, SCREEN_H)));
            default: queue_simple(lwpw_pkg::MODE_POLL, '0, '0, '0);
        endcase
    endtask

    task automatic queue_noise_item();
        cmd_t c;
        c = random_cmd();
        c.mode = 3'($urandom_range(0, 7));
        if (c.mode == lwpw_pkg::MODE_INDEX)
            c.palette_index = pick_loaded_index();
        queue_cmd(c);
    endtask

    task automatic queue_window_run();
        int x;
        int y;
        int w;
        int h;
        int n;
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 8);
        case ($urandom_range(0, 7))
            0: begin
                x = int'($urandom_range(0, 12)) - 8;
                y = int'($urandom_range(0, 6)) - 4;
            end
            1: begin
                x = $urandom_range(SCREEN_W - 10, SCREEN_W - 1);
                y = $urandom_range(SCREEN_H - 6, SCREEN_H - 1);
            end
            default: begin
                x = $urandom_range(0, SCREEN_W - 1);
                y = $urandom_range(0, SCREEN_H - 1);
            end
        endcase
        queue_window(x, y, w, h);
        n = $urandom_range(1, w * h + 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                queue_side_item();
            if ($urandom_range(0, 9) < 4)
                queue_pixel(1'b1, lwpw_pkg::RGB_W'($urandom), pick_loaded_index(),
                            i == n - 1);
            else
                queue_pixel(1'b0, lwpw_pkg::RGB_W'($urandom),
                            lwpw_pkg::INDEX_W'($urandom), i == n - 1);
        end
        if ($urandom_range(0, 1) == 0)
            queue_simple(lwpw_pkg::MODE_POLL, '0, '0, '0);
    endtask

    task automatic queue_directed();
        queue_simple(lwpw_pkg::MODE_POLL, '0, '0, '0);
        queue_simple(lwpw_pkg::MODE_POLL, '0, '0, '0);
        queue_simple(lwpw_pkg::MODE_SCROLL, '0, '0, lwpw_pkg::SCROLL_W'(SCREEN_H));
        queue_simple(lwpw_pkg::MODE_POLL, '0, '0, '0);
        queue_simple(lwpw_pkg::MODE_PAL_WR, 8'd0, 16'hFFFF, '0);
        queue_simple(lwpw_pkg::MODE_PAL_WR, 8'd255, 16'h0000, '0);
        queue_simple(lwpw_pkg::MODE_PAL_WR, 8'hA5, 16'hA55A, '0);
        // full screen window
        queue_window(0, 0, 1023, 1023);
        queue_pixel(1'b0, 16'hFFFF, '0, 1'b0);
        queue_pixel(1'b0, 16'h0000, '0, 1'b0);
        queue_pixel(1'b1, '0, 8'd255, 1'b0);
        queue_pixel(1'b1, '0, 8'd0, 1'b1);
        // negative origin clamps, 2x2 window wraps back to the top
        queue_window(-512, -512, 514, 514);
        for (int i = 0; i < 5; i++)
            queue_pixel(i[0], 16'h07E0, 8'hA5, i == 4);
        // origin past the frame, pixel is dropped
        queue_window(511, 511, 1023, 0);
        queue_pixel(1'b0, 16'hF800, '0, 1'b1);
        // last frame pixel, both edges wrap
        queue_window(SCREEN_W - 1, SCREEN_H - 1, 1, 1);
        queue_pixel(1'b0, 16'h001F, '0, 1'b0);
        queue_pixel(1'b0, 16'h1234, '0, 1'b1);
        // zero sized window, edges never reached
        queue_window(0, 0, 0, 0);
        queue_pixel(1'b0, 16'h8410, '0, 1'b1);
        queue_simple(MODE_SPARE_6, 8'hFF, 16'hFFFF, 9'h1FF);
        queue_simple(MODE_SPARE_7, 8'hFF, 16'hFFFF, 9'h1FF);
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_responses.push_back(writer_response(offered_cmd));
                in_beats <= in_beats + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, offered_cmd.scroll_line, offered_cmd.palette_index,
                                offered_cmd.pixel_value, offered_cmd.win_height,
                                offered_cmd.win_width, offered_cmd.win_y, offered_cmd.win_x};
                    s_tuser <= offered_cmd.mode;
                    s_tlast <= offered_cmd.run_end;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_used && in_beats >= HOLD_AFTER) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        response_t want;
        response_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.write_valid = m_tuser[0];
            got.bad_position = m_tuser[1];
            got.update_needed = m_tuser[2];
            got.write_address = m_tdata[16:0];
            got.write_argb = m_tdata[48:17];
            got.scroll_value = m_tdata[57:49];
            got.run_done = m_tlast;
            if (pending_responses.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result beat: valid=%0b addr=%0d argb=%h",
                             got.write_valid, got.write_address, got.write_argb);
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                if (got !== want) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("exp: v=%0b a=%0d argb=%h bad=%0b upd=%0b sc=%0d done=%0b",
                                 want.write_valid, want.write_address, want.write_argb,
                                 want.bad_position, want.update_needed, want.scroll_value,
                                 want.run_done);
                        $display("got: v=%0b a=%0d argb=%h bad=%0b upd=%0b sc=%0d done=%0b",
                                 got.write_valid, got.write_address, got.write_argb,
                                 got.bad_position, got.update_needed, got.scroll_value,
                                 got.run_done);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_cmds.size() == 0 && !s_tvalid && pending_responses.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        queue_directed();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct = 26;
                    recv_stall_pct = 26;
                end
            endcase
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 75)
                    queue_window_run();
                else
                    queue_noise_item();
            end
            if (phase == 0) begin
                repeat (8) @(posedge aclk);
                aresetn <= 1'b1;
            end
            // sender pauses until every result of the phase is back
            do @(negedge aclk);
            while (pending_cmds.size() != 0 || s_tvalid || pending_responses.size() != 0);
        end
        repeat (4) @(posedge aclk);
        if (pending_responses.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
